// ----- hw/rtl/terminal_line_editor_unit_macros.svh -----
// ============================================================================
// Terminal line editor assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk and disabled in reset.
// ============================================================================
`ifndef TERMINAL_LINE_EDITOR_UNIT_MACROS_SVH
`define TERMINAL_LINE_EDITOR_UNIT_MACROS_SVH

`ifndef SYNTH

// A property that must hold at every clock edge outside reset.
`define TLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define TLE_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`else

`define TLE_ASSERT(label, prop, msg)
`define TLE_ASSERT_NEXT(label, cond, conseq, msg)

`endif

`endif

// ----- hw/rtl/tle_pkg.sv -----
// ============================================================================
// Terminal line editor package
// Character codes, command encoding and sizing constants shared by the
// front end, the command queue and the back end.
// ============================================================================
package tle_pkg;

    // Default sizing.
    localparam int LINE_LEN_DEF = 64;
    localparam int Q_DEPTH_DEF  = 4;

    // Fill count width, wide enough for the largest supported line.
    localparam int CNT_W = 6;

    // Character codes.
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_FINAL_LO = 8'h40;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Commands passed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_ERASE = 2'd1,
        OP_LINE  = 2'd2
    } t_op;

    // For OP_STORE, arg is the write address; for OP_LINE, the line length.
    typedef struct packed {
        t_op              op;
        logic [6:0]       data;
        logic [CNT_W-1:0] arg;
    } t_cmd;

endpackage

// ----- hw/rtl/tle_front.sv -----
// ============================================================================
// Terminal line editor front end
// Accepts received bytes, tracks escape sequences and the fill count, and
// queues one command for every byte that produces output.
// ============================================================================
module tle_front import tle_pkg::*; #(
    parameter int LINE_LEN = LINE_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  logic       i_q_full
);

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_SEEN = 2'd1,
        ESC_CSI  = 2'd2
    } t_esc_mode;

    t_esc_mode        r_mode, n_mode;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             accept;
    logic             is_final;
    logic             is_print;

    // A byte is taken whenever the queue has space for its command.
    assign o_stall  = i_q_full;
    assign accept   = i_valid && !i_q_full;
    assign is_final = (i_rx_byte >= CH_FINAL_LO) && (i_rx_byte <= CH_TILDE);
    assign is_print = (i_rx_byte >= CH_SPACE) && (i_rx_byte <= CH_TILDE);

    // Classify the byte and build its command.
    always_comb begin
        n_mode = r_mode;
        n_fill = r_fill;
        o_push = 1'b0;
        o_cmd  = '{op: OP_STORE, data: i_rx_byte[6:0], arg: r_fill};
        if (accept) begin
            unique case (r_mode)
                ESC_SEEN: begin
                    n_mode = (i_rx_byte == CH_LBRK) ? ESC_CSI : ESC_IDLE;
                end
                ESC_CSI: begin
                    if (is_final) begin
                        n_mode = ESC_IDLE;
                    end
                end
                default: begin
                    priority if (i_rx_byte == CH_ESC) begin
                        n_mode = ESC_SEEN;
                    end else if (i_rx_byte == CH_CR || i_rx_byte == CH_LF) begin
                        o_push    = 1'b1;
                        o_cmd.op  = OP_LINE;
                        o_cmd.arg = r_fill;
                        n_fill    = '0;
                    end else if (i_rx_byte == CH_DEL || i_rx_byte == CH_BS) begin
                        if (r_fill != '0) begin
                            o_push   = 1'b1;
                            o_cmd.op = OP_ERASE;
                            n_fill   = r_fill - CNT_W'(1);
                        end
                    end else if (is_print && r_fill < CNT_W'(LINE_LEN - 1)) begin
                        o_push   = 1'b1;
                        o_cmd.op = OP_STORE;
                        n_fill   = r_fill + CNT_W'(1);
                    end else begin
                        // Other control bytes, high bytes and printable bytes
                        // on a full line are dropped.
                        o_push = 1'b0;
                    end
                end
            endcase
        end
    end

    // Escape tracker and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ESC_IDLE;
            r_fill <= '0;
        end else begin
            r_mode <= n_mode;
            r_fill <= n_fill;
        end
    end

endmodule

// ----- hw/rtl/tle_cmd_fifo.sv -----
// ============================================================================
// Terminal line editor command queue
// Small register FIFO that decouples the front end from the back end.
// ============================================================================
`include "terminal_line_editor_unit_macros.svh"

module tle_cmd_fifo import tle_pkg::*; #(
    parameter int DEPTH = Q_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    // The user must keep DEPTH a power of two so the pointers wrap on their own; the block does not enforce it.
    localparam int PW = $clog2(DEPTH);

    t_cmd        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `TLE_ASSERT(a_no_overflow, !(i_push && o_full), "command pushed into a full queue")
    `TLE_ASSERT(a_no_underflow, !(i_pop && o_empty), "command popped from an empty queue")
    `TLE_ASSERT(a_count_range, r_count <= (PW+1)'(DEPTH), "queue occupancy out of range")
    `TLE_ASSERT_NEXT(a_push_fills, i_push && !i_pop, !o_empty, "queue empty after a push")

endmodule

// ----- hw/rtl/tle_back.sv -----
// ============================================================================
// Terminal line editor back end
// Executes queued commands: writes the line buffer, produces echo bytes and
// drains a finished line through a registered output stage.
// ============================================================================
`include "terminal_line_editor_unit_macros.svh"

module tle_back import tle_pkg::*; #(
    parameter int LINE_LEN = LINE_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_q_cmd,
    input  logic       i_q_empty,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_to_line,
    output logic       o_line_empty,
    output logic       o_last
);

    localparam int AW = $clog2(LINE_LEN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERASE_SP,
        S_ERASE_BS,
        S_EMPTY,
        S_LINE
    } t_state;

    // Line buffer.
    logic [6:0] r_line [LINE_LEN];
    logic [6:0] r_rdata;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_o_valid, n_o_valid;
    logic [7:0]       r_o_byte, n_o_byte;
    logic             r_o_to_line, n_o_to_line;
    logic             r_o_empty, n_o_empty;
    logic             r_o_last, n_o_last;

    logic          can_emit;
    logic          mem_we;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          line_end;

    // The output register can take a new result when empty or being drained.
    assign can_emit = !r_o_valid || !i_stall;
    assign line_end = (r_idx == r_cnt - CNT_W'(1));

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_o_valid   = r_o_valid && i_stall;
        n_o_byte    = r_o_byte;
        n_o_to_line = r_o_to_line;
        n_o_empty   = r_o_empty;
        n_o_last    = r_o_last;
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        if (can_emit) begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        o_q_pop     = 1'b1;
                        n_o_valid   = 1'b1;
                        n_o_to_line = 1'b0;
                        n_o_empty   = 1'b0;
                        n_o_last    = 1'b0;
                        unique case (i_q_cmd.op)
                            OP_STORE: begin
                                // Store the character and echo it.
                                mem_we   = 1'b1;
                                n_o_byte = {1'b0, i_q_cmd.data};
                                n_o_last = 1'b1;
                            end
                            OP_ERASE: begin
                                n_o_byte = CH_BS;
                                n_state  = S_ERASE_SP;
                            end
                            OP_LINE: begin
                                // Echo the newline and, for a non-empty line, fetch the first byte.
                                n_o_byte = CH_LF;
                                if (i_q_cmd.arg == '0) begin
                                    n_state = S_EMPTY;
                                end else begin
                                    n_cnt   = i_q_cmd.arg;
                                    n_idx   = '0;
                                    rd_en   = 1'b1;
                                    rd_addr = '0;
                                    n_state = S_LINE;
                                end
                            end
                            default: begin
                                n_o_valid = 1'b0;
                            end
                        endcase
                    end
                end
                S_ERASE_SP: begin
                    n_o_valid = 1'b1;
                    n_o_byte  = CH_SPACE;
                    n_state   = S_ERASE_BS;
                end
                S_ERASE_BS: begin
                    n_o_valid = 1'b1;
                    n_o_byte  = CH_BS;
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end
                S_EMPTY: begin
                    n_o_valid   = 1'b1;
                    n_o_byte    = CH_NUL;
                    n_o_to_line = 1'b1;
                    n_o_empty   = 1'b1;
                    n_o_last    = 1'b1;
                    n_state     = S_IDLE;
                end
                S_LINE: begin
                    // Emit the fetched byte and, unless it ends the line, fetch the next one.
                    n_o_valid   = 1'b1;
                    n_o_byte    = {1'b0, r_rdata};
                    n_o_to_line = 1'b1;
                    n_o_empty   = 1'b0;
                    n_o_last    = line_end;
                    if (line_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        rd_en   = 1'b1;
                        rd_addr = n_idx[AW-1:0];
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // Line buffer write and registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line[i_q_cmd.arg[AW-1:0]] <= i_q_cmd.data;
        end
        if (rd_en) begin
            r_rdata <= r_line[rd_addr];
        end
    end

    // Sequencer state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_idx     <= '0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_idx     <= n_idx;
            r_cnt     <= n_cnt;
        end
        r_o_byte    <= n_o_byte;
        r_o_to_line <= n_o_to_line;
        r_o_empty   <= n_o_empty;
        r_o_last    <= n_o_last;
    end

    assign o_valid      = r_o_valid;
    assign o_out_byte   = r_o_byte;
    assign o_to_line    = r_o_to_line;
    assign o_line_empty = r_o_empty;
    assign o_last       = r_o_last;

    `TLE_ASSERT(a_idx_in_line, (r_state != S_LINE) || (r_idx < r_cnt), "line index past line length")
    `TLE_ASSERT(a_pop_in_idle, !o_q_pop || (r_state == S_IDLE), "command taken while busy")
    `TLE_ASSERT(a_empty_marker, !(r_o_valid && r_o_empty) || (r_o_to_line && r_o_last && (r_o_byte == CH_NUL)), "malformed empty-line marker")
    `TLE_ASSERT_NEXT(a_line_drains, (r_state == S_LINE) && can_emit, r_o_valid && r_o_to_line, "line byte not presented")

endmodule

// ----- hw/rtl/terminal_line_editor_unit.sv -----
// ============================================================================
// Terminal line editor
// Line discipline for a received terminal byte stream with escape skipping.
// ============================================================================
// A received byte is taken whenever the command queue between the front end
// and the back end has space (four entries by default); while the queue is
// full every byte waits, including bytes that give no result. Results leave
// through one output register at up to one per cycle while the output is not
// stalled: a stored character gives its echo, an erase gives three echo bytes
// (backspace, space, backspace), and a finished line of n bytes gives the
// newline echo and then its n bytes in order, read from the line buffer, whose
// registered read is overlapped with the echo; an empty line gives the newline
// echo and an empty-line marker. A stalled output holds the back end but not
// the front end until the queue fills.
module terminal_line_editor_unit import tle_pkg::*; #(
    parameter int LINE_LEN    = LINE_LEN_DEF,
    parameter int QUEUE_DEPTH = Q_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_to_line,
    output logic       o_line_empty,
    output logic       o_last
);

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    t_cmd push_cmd;
    t_cmd pop_cmd;

    // Byte classification and line bookkeeping.
    tle_front #(
        .LINE_LEN (LINE_LEN)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_cmd     (push_cmd),
        .i_q_full  (q_full)
    );

    // Command queue.
    tle_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (q_empty)
    );

    // Command execution and result transfer.
    tle_back #(
        .LINE_LEN (LINE_LEN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_cmd      (pop_cmd),
        .i_q_empty    (q_empty),
        .o_q_pop      (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_to_line    (o_to_line),
        .o_line_empty (o_line_empty),
        .o_last       (o_last)
    );

endmodule
